// ===== sv/bfsec_pkg.sv =====
package bfsec_pkg;

   localparam int NUM_IN_BYTES = 4;
   localparam int REQ_W = 56;
   localparam int RSP_W = 16;
   localparam int CSR_AW = 3;
   localparam logic CSR_ECHO_TIMEOUT = 1'b0;
   localparam logic [15:0] ECHO_TIMEOUT_RESET = 16'd1035;
   localparam logic [15:0] WAIT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_ECHO  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT_IDLE,
      PH_WAIT_ECHO
   } phase_type;

   typedef enum logic [2:0] {
      ST_NONE     = 3'd0,
      ST_GOOD     = 3'd1,
      ST_TIMEOUT  = 3'd2,
      ST_MISMATCH = 3'd3,
      ST_BUSY     = 3'd4
   } status_type;

   typedef struct packed {
      logic       bus_idle;
      logic [7:0] echo_byte;
      logic [7:0] data_byte_3;
      logic [7:0] data_byte_2;
      logic [7:0] data_byte_1;
      logic [7:0] data_byte_0;
      logic [2:0] data_count;
      logic [7:0] msg_id;
   } req_type;

   typedef struct packed {
      logic       busy_res;
      status_type status;
      logic       done_res;
      logic [7:0] tx_byte;
      logic       tx_valid;
   } rsp_type;

endpackage

// ===== sv/bfsec_csr.sv =====
module bfsec_csr
   import bfsec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output logic [15:0]       echo_timeout
);

   logic [15:0] echo_timeout_ff;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready
                  & (csr_paddr[2] == CSR_ECHO_TIMEOUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_timeout_ff <= ECHO_TIMEOUT_RESET;
      end else if (wr_en) begin
         echo_timeout_ff <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_ECHO_TIMEOUT) begin
         csr_prdata = {16'd0, echo_timeout_ff};
      end
   end

   assign echo_timeout = echo_timeout_ff;

endmodule

// ===== sv/bfsec_core.sv =====
module bfsec_core
   import bfsec_pkg::*;
#(
   parameter int MAX_DATA_BYTES = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  cmd_type     cmd,
   input  req_type     req,
   input  logic [15:0] echo_timeout,
   output rsp_type     result
);

   localparam int CNT_W = $clog2(MAX_DATA_BYTES + 2);
   localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

   phase_type  phase_ff, phase_in;
   logic [7:0] frame_bytes_ff [MAX_DATA_BYTES];
   logic [7:0] frame_bytes_in [MAX_DATA_BYTES];
   logic [7:0] frame_id_ff, frame_id_in;
   logic [CNT_W-1:0] byte_total_ff, byte_total_in;
   logic [CNT_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] expected_echo_ff, expected_echo_in;
   logic [15:0] wait_count_ff, wait_count_in;

   logic [7:0] in_bytes [NUM_IN_BYTES];
   logic [7:0] cur_byte;
   logic [15:0] wait_inc;

   assign in_bytes[0] = req.data_byte_0;
   assign in_bytes[1] = req.data_byte_1;
   assign in_bytes[2] = req.data_byte_2;
   assign in_bytes[3] = req.data_byte_3;

   assign cur_byte = frame_bytes_ff[byte_index_ff[IDX_W-1:0]];
   assign wait_inc = (wait_count_ff != WAIT_MAX) ? wait_count_ff + 16'd1 : wait_count_ff;

   always_comb begin
      phase_in = phase_ff;
      for (int i = 0; i < MAX_DATA_BYTES; i++) begin
         frame_bytes_in[i] = frame_bytes_ff[i];
      end
      frame_id_in = frame_id_ff;
      byte_total_in = byte_total_ff;
      byte_index_in = byte_index_ff;
      running_sum_in = running_sum_ff;
      expected_echo_in = expected_echo_ff;
      wait_count_in = wait_count_ff;
      result = '0;
      result.status = ST_NONE;

      case (cmd)
         CMD_START: begin
            if (phase_ff != PH_IDLE) begin
               result.status = ST_BUSY;
            end else begin
               if (int'(req.data_count) > MAX_DATA_BYTES) begin
                  byte_total_in = CNT_W'(MAX_DATA_BYTES);
               end else begin
                  byte_total_in = CNT_W'(req.data_count);
               end
               frame_id_in = req.msg_id;
               for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                  frame_bytes_in[i] = (i < NUM_IN_BYTES) ? in_bytes[i % NUM_IN_BYTES] : 8'h00;
               end
               byte_index_in = '0;
               running_sum_in = '0;
               wait_count_in = '0;
               phase_in = PH_WAIT_IDLE;
            end
         end
         CMD_TICK: begin
            if (phase_ff == PH_WAIT_IDLE) begin
               if (req.bus_idle) begin
                  running_sum_in = frame_id_ff;
                  byte_index_in = '0;
                  result.tx_valid = 1'b1;
                  result.tx_byte = frame_id_ff;
                  expected_echo_in = frame_id_ff;
                  wait_count_in = '0;
                  phase_in = PH_WAIT_ECHO;
               end
            end else if (phase_ff == PH_WAIT_ECHO) begin
               wait_count_in = wait_inc;
               if (wait_inc >= echo_timeout) begin
                  phase_in = PH_IDLE;
                  result.done_res = 1'b1;
                  result.status = ST_TIMEOUT;
               end
            end
         end
         CMD_ECHO: begin
            if (phase_ff == PH_WAIT_ECHO) begin
               if (req.echo_byte != expected_echo_ff) begin
                  phase_in = PH_IDLE;
                  result.done_res = 1'b1;
                  result.status = ST_MISMATCH;
               end else if (byte_index_ff < byte_total_ff) begin
                  running_sum_in = running_sum_ff + cur_byte;
                  byte_index_in = byte_index_ff + CNT_W'(1);
                  result.tx_valid = 1'b1;
                  result.tx_byte = cur_byte;
                  expected_echo_in = cur_byte;
                  wait_count_in = '0;
               end else if (byte_index_ff == byte_total_ff) begin
                  byte_index_in = byte_index_ff + CNT_W'(1);
                  result.tx_valid = 1'b1;
                  result.tx_byte = running_sum_ff;
                  expected_echo_in = running_sum_ff;
                  wait_count_in = '0;
               end else begin
                  phase_in = PH_IDLE;
                  result.done_res = 1'b1;
                  result.status = ST_GOOD;
               end
            end
         end
         default: begin
         end
      endcase

      result.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         frame_id_ff <= '0;
         byte_total_ff <= '0;
         byte_index_ff <= '0;
         running_sum_ff <= '0;
         expected_echo_ff <= '0;
         wait_count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         frame_id_ff <= frame_id_in;
         byte_total_ff <= byte_total_in;
         byte_index_ff <= byte_index_in;
         running_sum_ff <= running_sum_in;
         expected_echo_ff <= expected_echo_in;
         wait_count_ff <= wait_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < MAX_DATA_BYTES; i++) begin
            frame_bytes_ff[i] <= frame_bytes_in[i];
         end
      end
   end

   a_done_ends_frame: assert property (@(posedge clock) disable iff (reset)
      result.done_res |-> !result.busy_res)
      else $error("finished frame still busy");

   a_send_waits_echo: assert property (@(posedge clock) disable iff (reset)
      (accept && result.tx_valid) |=> (phase_ff == PH_WAIT_ECHO))
      else $error("byte sent without waiting for echo");

   a_reject_keeps_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && result.status == ST_BUSY) |=> (phase_ff != PH_IDLE && $stable(frame_id_ff)))
      else $error("rejected start disturbed running frame");

endmodule

// ===== sv/bus_frame_sender_echo_check_unit.sv =====
// Frame sender with echo check for a shared echoing serial bus.
// req_ carries one event per request: tuser is the command (start, echo
// byte, microsecond tick) and tdata the frame fields, echo byte and the
// bus-idle level. Every accepted request yields exactly one response on
// rsp_: the byte to put on the bus now (if any), a done flag with status
// and the busy level after the event.
// A start latches the frame; ticks wait for bus idle and then send the ID.
// Each echo that matches sends the next byte (data, then checksum); the
// echo of the checksum ends the frame good. A wrong echo or echo_timeout
// ticks without echo end it failed. Starts while busy are answered with
// the reject status and otherwise ignored.
// Responses go to an output register plus one skid entry; the skid entry
// takes one only while the output register is full. One request per cycle
// is accepted; req_tready drops only when both hold undelivered responses.
// Reset returns the sender to idle, empties the response buffer and loads
// echo_timeout with 1035. csr_ is an APB port with echo_timeout at 0x0.
module bus_frame_sender_echo_check_unit
   import bfsec_pkg::*;
#(
   parameter int MAX_DATA_BYTES = 4
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // msg_id[7:0], data_count[10:8], data_byte_0[18:11], data_byte_1[26:19],
   // data_byte_2[34:27], data_byte_3[42:35], echo_byte[50:43], bus_idle[51]
   input  logic [REQ_W-1:0]  req_tdata,
   // command[1:0]
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // tx_valid[0], tx_byte[8:1], done_res[9], status[12:10], busy_res[13]
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [15:0] echo_timeout;
   logic        accept;
   logic        pop;
   req_type     req;
   rsp_type     result;

   logic              out_valid_ff;
   logic              skid_valid_ff;
   logic [RSP_W-1:0]  out_data_ff;
   logic [RSP_W-1:0]  skid_data_ff;
   logic [RSP_W-1:0]  result_data;

   bfsec_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .echo_timeout (echo_timeout)
   );

   assign req = req_type'(req_tdata[$bits(req_type)-1:0]);

   bfsec_core #(
      .MAX_DATA_BYTES (MAX_DATA_BYTES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (cmd_type'(req_tuser)),
      .req          (req),
      .echo_timeout (echo_timeout),
      .result       (result)
   );

   assign result_data = RSP_W'(result);

   assign req_tready = !skid_valid_ff;
   assign accept = req_tvalid & req_tready;
   assign pop = out_valid_ff & rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : result_data;
      end else if (accept) begin
         skid_data_ff <= result_data;
      end
   end

endmodule

// ===== dv/frame_echo_checker.sv =====
module frame_echo_checker
   import bfsec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic [1:0]        req_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   input  logic              csr_pready,
   output int unsigned       failures,
   output int unsigned       open_count,
   output int unsigned       checked
);

   localparam logic [CSR_AW-1:0] TIMEOUT_ADDR = CSR_AW'(4 * CSR_ECHO_TIMEOUT);
   localparam int MAX_DATA = NUM_IN_BYTES;

   phase_type   phase;
   logic [7:0]  frame_data [MAX_DATA];
   logic [7:0]  frame_id;
   logic [7:0]  check_sum;
   logic [7:0]  echo_want;
   logic [2:0]  data_total;
   logic [2:0]  sent_index;
   logic [15:0] echo_wait;
   logic [15:0] echo_limit;
   rsp_type     expected_q [$];

   function automatic void put_on_bus(input logic [7:0] b, inout rsp_type o);
      o.tx_valid = 1'b1;
      o.tx_byte = b;
      echo_want = b;
      echo_wait = '0;
      phase = PH_WAIT_ECHO;
   endfunction

   function automatic rsp_type frame_step(input cmd_type c, input req_type r);
      rsp_type    o;
      logic [7:0] b;
      o = '0;
      case (c)
         CMD_START: begin
            if (phase != PH_IDLE) begin
               o.status = ST_BUSY;
            end else begin
               data_total = (r.data_count > 3'(MAX_DATA)) ? 3'(MAX_DATA) : r.data_count;
               frame_id = r.msg_id;
               frame_data = '{r.data_byte_0, r.data_byte_1, r.data_byte_2, r.data_byte_3};
               sent_index = '0;
               check_sum = '0;
               echo_wait = '0;
               phase = PH_WAIT_IDLE;
            end
         end
         CMD_TICK: begin
            if (phase == PH_WAIT_IDLE) begin
               if (r.bus_idle) begin
                  check_sum = frame_id;
                  sent_index = '0;
                  put_on_bus(frame_id, o);
               end
            end else if (phase == PH_WAIT_ECHO) begin
               if (echo_wait != WAIT_MAX) echo_wait++;
               if (echo_wait >= echo_limit) begin
                  phase = PH_IDLE;
                  o.done_res = 1'b1;
                  o.status = ST_TIMEOUT;
               end
            end
         end
         CMD_ECHO: begin
            if (phase == PH_WAIT_ECHO) begin
               if (r.echo_byte != echo_want) begin
                  phase = PH_IDLE;
                  o.done_res = 1'b1;
                  o.status = ST_MISMATCH;
               end else if (sent_index < data_total) begin
                  b = frame_data[sent_index[1:0]];
                  check_sum = check_sum + b;
                  sent_index++;
                  put_on_bus(b, o);
               end else if (sent_index == data_total) begin
                  sent_index++;
                  put_on_bus(check_sum, o);
               end else begin
                  phase = PH_IDLE;
                  o.done_res = 1'b1;
                  o.status = ST_GOOD;
               end
            end
         end
         default: ;
      endcase
      o.busy_res = (phase != PH_IDLE);
      return o;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      req_type r;
      if (reset) begin
         phase = PH_IDLE;
         frame_id = '0;
         check_sum = '0;
         echo_want = '0;
         data_total = '0;
         sent_index = '0;
         echo_wait = '0;
         echo_limit = ECHO_TIMEOUT_RESET;
         expected_q.delete();
         failures = 0;
         open_count = 0;
         checked = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == TIMEOUT_ADDR)
            echo_limit = csr_pwdata[15:0];
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_type)-1:0];
            if (expected_q.size() == 0) begin
               $display("%0t: response expected none got %h", $time, got);
               failures++;
            end else begin
               want = expected_q.pop_front();
               checked++;
               check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
               check_field("tx_byte", want.tx_byte, got.tx_byte);
               check_field("done_res", 8'(want.done_res), 8'(got.done_res));
               check_field("status", 8'(want.status), 8'(got.status));
               check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            end
         end
         if (req_tvalid && req_tready) begin
            r = req_tdata[$bits(req_type)-1:0];
            expected_q.push_back(frame_step(cmd_type'(req_tuser), r));
         end
         open_count = expected_q.size();
      end
   end

endmodule

// ===== dv/tb.sv =====
module tb;
   import bfsec_pkg::*;

   localparam int ITEMS = 1150;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [CSR_AW-1:0] TIMEOUT_ADDR = CSR_AW'(4 * CSR_ECHO_TIMEOUT);

   typedef enum int {FATE_GOOD, FATE_TIMEOUT, FATE_MISMATCH} fate_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic [1:0]        req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   int unsigned failures;
   int unsigned open_count;
   int unsigned checked;
   int          cycle_count;
   int          req_calm;
   int          rsp_calm;
   bit          hurry;
   int          cur_timeout;
   int          frame_requests;
   int          fate_count [3];
   int          settings_run;

   bus_frame_sender_echo_check_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frame_echo_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .open_count  (open_count),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("stopped after %0d cycles, %0d responses outstanding", cycle_count, open_count);
      $display("RESULT: ERROR");
      $finish;
   end

   // gaps drawn at random, with occasional stretches of back-to-back traffic
   function automatic int draw_gap(inout int calm);
      if (hurry) return 0;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   function automatic req_type rand_req();
      logic [63:0] raw;
      req_type     r;
      raw = {$urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      return r;
   endfunction

   // entered and left at a falling edge; valid stays high on return
   task automatic send_req(input cmd_type c, input req_type r);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_W - $bits(req_type)){1'b0}}, r};
      req_tuser <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      frame_requests++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (open_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_echo_limit(input int value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= TIMEOUT_ADDR;
      csr_pwdata <= {16'($urandom), 16'(value)};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      cur_timeout = value;
      settings_run++;
   endtask

   task automatic idle_noise();
      case ($urandom_range(0, 2))
         0: send_req(CMD_ECHO, rand_req());
         1: send_req(CMD_TICK, rand_req());
         default: send_req(CMD_NONE, rand_req());
      endcase
   endtask

   task automatic run_frame(input logic [7:0] id, input logic [2:0] cnt,
                            input logic [3:0][7:0] d, input fate_type fate,
                            input int fail_at, input bit extras);
      req_type    r;
      int         n;
      int         waits;
      int         k;
      logic [7:0] echoes [NUM_IN_BYTES+2];
      logic [7:0] sum;
      n = (cnt > NUM_IN_BYTES) ? NUM_IN_BYTES : cnt;
      fate_count[fate]++;
      r = rand_req();
      r.msg_id = id;
      r.data_count = cnt;
      r.data_byte_0 = d[0];
      r.data_byte_1 = d[1];
      r.data_byte_2 = d[2];
      r.data_byte_3 = d[3];
      send_req(CMD_START, r);
      // busy reject and an echo before the bus is free, both to be ignored
      if (extras || $urandom_range(0, 7) == 0) begin
         send_req(CMD_START, rand_req());
         send_req(CMD_ECHO, rand_req());
      end
      waits = extras ? 1 : $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0) waits = 30;
      repeat (waits) begin
         r = rand_req();
         r.bus_idle = 1'b0;
         send_req(CMD_TICK, r);
      end
      r = rand_req();
      r.bus_idle = 1'b1;
      send_req(CMD_TICK, r);
      echoes[0] = id;
      sum = id;
      for (int i = 0; i < n; i++) begin
         echoes[i+1] = d[i];
         sum = sum + d[i];
      end
      echoes[n+1] = sum;
      for (int i = 0; i <= n + 1; i++) begin
         if (fate == FATE_TIMEOUT && i == fail_at) begin
            hurry = (cur_timeout > 100);
            repeat ((cur_timeout == 0) ? 1 : cur_timeout) send_req(CMD_TICK, rand_req());
            hurry = 1'b0;
            return;
         end
         k = 0;
         if (cur_timeout > 1 && $urandom_range(0, 3) == 0)
            k = $urandom_range(1, (cur_timeout - 1 < 4) ? cur_timeout - 1 : 4);
         repeat (k) send_req(CMD_TICK, rand_req());
         if ($urandom_range(0, 9) == 0) send_req(CMD_START, rand_req());
         if ($urandom_range(0, 15) == 0) send_req(CMD_NONE, rand_req());
         r = rand_req();
         r.echo_byte = echoes[i];
         if (fate == FATE_MISMATCH && i == fail_at)
            r.echo_byte = echoes[i] ^ 8'($urandom_range(1, 255));
         send_req(CMD_ECHO, r);
         if (fate == FATE_MISMATCH && i == fail_at) return;
      end
   endtask

   task automatic random_frame();
      fate_type    f;
      logic [2:0]  cnt;
      int          n;
      cnt = 3'($urandom_range(0, 7));
      n = (cnt > NUM_IN_BYTES) ? NUM_IN_BYTES : cnt;
      case ($urandom_range(0, 9))
         0, 1: f = FATE_MISMATCH;
         2, 3: f = (cur_timeout <= 40) ? FATE_TIMEOUT : FATE_GOOD;
         default: f = FATE_GOOD;
      endcase
      run_frame(8'($urandom), cnt, $urandom, f, $urandom_range(0, n + 1),
                $urandom_range(0, 15) == 0);
   endtask

   // response side: a random stall, possibly none, before taking each response
   initial begin
      int gap;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      int     echo_limits [$];
      int     quota;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_NONE;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hurry = 1'b0;
      req_calm = 0;
      rsp_calm = 0;
      frame_requests = 0;
      settings_run = 1;
      fate_count = '{0, 0, 0};
      cur_timeout = ECHO_TIMEOUT_RESET;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: stray requests while idle, empty and saturated frames,
      // busy reject, echo before bus idle, bad checksum echo
      send_req(CMD_ECHO, rand_req());
      send_req(CMD_TICK, rand_req());
      send_req(CMD_NONE, rand_req());
      run_frame(8'h00, 3'd0, '0, FATE_GOOD, 0, 1'b1);
      run_frame(8'hFF, 3'd7, '1, FATE_GOOD, 0, 1'b0);
      run_frame(8'h5A, 3'd4, 32'hA5_01_80_7F, FATE_MISMATCH, 5, 1'b0);

      echo_limits = '{ECHO_TIMEOUT_RESET, 0, 1, 2, 7, 65535, $urandom_range(3, 40),
                      $urandom_range(41, 3000), ECHO_TIMEOUT_RESET};
      for (int p = 0; p < echo_limits.size(); p++) begin
         if (p > 0) begin
            settle();
            write_echo_limit(echo_limits[p]);
         end
         quota = ITEMS * (p + 1) / echo_limits.size();
         while (frame_requests < quota) begin
            if ($urandom_range(0, 3) == 0) idle_noise();
            random_frame();
         end
      end

      settle();
      repeat (10) @(negedge clock);
      $display("frames sent: %0d aimed good, %0d at echo timeout, %0d at echo mismatch",
               fate_count[FATE_GOOD], fate_count[FATE_TIMEOUT], fate_count[FATE_MISMATCH]);
      $display("%0d responses checked over %0d echo timeout settings, %0d cycles",
               checked, settings_run, cycle_count);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", failures);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
